// ===== rtl/drrip_pkg.sv =====
// Shared constants, types and the controller-to-datapath command word
// for the DRRIP replacement block. No dependencies.
package drrip_pkg;

   localparam int SETS        = 2048;
   localparam int SET_BITS    = 11;
   localparam int WAYS        = 16;
   localparam int WAY_BITS    = 4;
   localparam int AGE_BITS    = 2;
   localparam int SEL_BITS    = 10;
   localparam int SAMPLE_BITS = 6;
   localparam int HASH_LSB    = 3;
   localparam int HASH_BITS   = 5;

   localparam logic [AGE_BITS-1:0] RRPV_TOP = {AGE_BITS{1'b1}};
   localparam logic [SEL_BITS-1:0] SEL_TOP  = {SEL_BITS{1'b1}};
   localparam logic [SEL_BITS-1:0] SEL_MID  = {1'b0, {(SEL_BITS-1){1'b1}}};

   localparam logic [SAMPLE_BITS-1:0] PHASE_MRU = SAMPLE_BITS'(0);
   localparam logic [SAMPLE_BITS-1:0] PHASE_BIP = SAMPLE_BITS'(1);

   localparam logic OP_FIND   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   localparam int REQ_DATA_BITS = 144;
   localparam int RSP_DATA_BITS = 16;

   typedef logic [WAYS-1:0][AGE_BITS-1:0] row_type;

   typedef struct packed {
      logic                clear_wr;
      logic [SET_BITS-1:0] clear_row;
      logic                load;
      logic                exec;
   } cmd_type;

endpackage

// ===== rtl/drrip_ctrl.sv =====
// Sequencing controller for the DRRIP replacement block: reset clearing
// pass, request acceptance and result handshake. Uses drrip_pkg.
module drrip_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output drrip_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [drrip_pkg::SET_BITS-1:0] clear_row_ff, clear_row_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      clear_row_in = clear_row_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            clear_row_in = clear_row_ff + 1'b1;
            if (&clear_row_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd.clear_wr  = (state_ff == ST_CLEAR);
      cmd.clear_row = clear_row_ff;
      cmd.load      = accept;
      cmd.exec      = (state_ff == ST_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_row_ff <= clear_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted word is always executed in the following cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted word not executed next cycle");

   // Execution always leaves a result pending for the consumer.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> rsp_valid_ff)
      else $error("execution produced no result");

   // Nothing is accepted while the set memory is being cleared.
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("request accepted during clearing pass");

   // A result only appears after an execution cycle.
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("result raised without execution");

endmodule

// ===== rtl/drrip_dp.sv =====
// Datapath of the DRRIP replacement block: set row memory, aging and
// victim search, insertion logic, dueling selector and result register.
// Uses drrip_pkg; driven by drrip_ctrl commands.
module drrip_dp (
   input  logic                              clock,
   input  drrip_pkg::cmd_type                cmd,
   input  logic                              req_operation,
   input  logic [drrip_pkg::SET_BITS-1:0]    req_set_index,
   input  logic [drrip_pkg::WAY_BITS-1:0]    req_way_index,
   input  logic                              req_was_hit,
   input  logic [63:0]                       req_pc_value,
   input  logic [63:0]                       req_phys_address,
   output logic [drrip_pkg::WAY_BITS-1:0]    rsp_victim_way,
   output logic [drrip_pkg::SEL_BITS-1:0]    rsp_selector_value,
   input  logic                              reset
);

   drrip_pkg::row_type mem [drrip_pkg::SETS];

   drrip_pkg::row_type                    rd_row_ff;
   logic                                  op_ff;
   logic [drrip_pkg::SET_BITS-1:0]        set_ff;
   logic [drrip_pkg::WAY_BITS-1:0]        way_ff;
   logic                                  hit_ff;
   logic                                  hash_zero_ff;
   logic [drrip_pkg::SEL_BITS-1:0]        sel_ff, sel_in;
   logic [drrip_pkg::WAY_BITS-1:0]        victim_ff, victim_in;

   logic [drrip_pkg::AGE_BITS-1:0]        oldest;
   logic [drrip_pkg::AGE_BITS-1:0]        step;
   drrip_pkg::row_type                    aged_row;
   drrip_pkg::row_type                    upd_row;
   drrip_pkg::row_type                    new_row;
   logic [drrip_pkg::SAMPLE_BITS-1:0]     phase;
   logic                                  use_mru;
   logic [drrip_pkg::AGE_BITS-1:0]        ins_value;
   logic                                  any_hi;
   logic                                  any_lo;
   logic                                  wr_en;
   logic [drrip_pkg::SET_BITS-1:0]        wr_addr;
   drrip_pkg::row_type                    wr_row;

   // The oldest value is found bit by bit from the top, then every way is
   // shifted up by the same amount so that the oldest reaches the maximum.
   always_comb begin
      any_hi = 1'b0;
      any_lo = 1'b0;
      for (int w = 0; w < drrip_pkg::WAYS; w++) begin
         any_hi = any_hi | rd_row_ff[w][1];
      end
      for (int w = 0; w < drrip_pkg::WAYS; w++) begin
         any_lo = any_lo | (rd_row_ff[w][0] & (rd_row_ff[w][1] == any_hi));
      end
      oldest = {any_hi, any_lo};
      step   = drrip_pkg::RRPV_TOP - oldest;
      for (int w = 0; w < drrip_pkg::WAYS; w++) begin
         aged_row[w] = rd_row_ff[w] + step;
      end
      victim_in = victim_ff;
      if (cmd.exec) begin
         victim_in = '0;
         if (op_ff == drrip_pkg::OP_FIND) begin
            for (int w = drrip_pkg::WAYS - 1; w >= 0; w--) begin
               if (aged_row[w] == drrip_pkg::RRPV_TOP) begin
                  victim_in = drrip_pkg::WAY_BITS'(w);
               end
            end
         end
      end
   end

   always_comb begin
      phase = set_ff[drrip_pkg::SAMPLE_BITS-1:0];
      if (phase == drrip_pkg::PHASE_MRU) begin
         use_mru = 1'b1;
      end else if (phase == drrip_pkg::PHASE_BIP) begin
         use_mru = 1'b0;
      end else begin
         use_mru = (sel_ff >= drrip_pkg::SEL_MID);
      end
      if (hit_ff || use_mru || hash_zero_ff) begin
         ins_value = '0;
      end else begin
         ins_value = drrip_pkg::RRPV_TOP;
      end
      upd_row         = rd_row_ff;
      upd_row[way_ff] = ins_value;
      new_row = (op_ff == drrip_pkg::OP_FIND) ? aged_row : upd_row;

      sel_in = sel_ff;
      if (cmd.exec && op_ff == drrip_pkg::OP_UPDATE && hit_ff) begin
         if (phase == drrip_pkg::PHASE_MRU && sel_ff != drrip_pkg::SEL_TOP) begin
            sel_in = sel_ff + 1'b1;
         end else if (phase == drrip_pkg::PHASE_BIP && sel_ff != '0) begin
            sel_in = sel_ff - 1'b1;
         end
      end
   end

   always_comb begin
      wr_en   = cmd.clear_wr | cmd.exec;
      wr_addr = cmd.clear_wr ? cmd.clear_row : set_ff;
      wr_row  = cmd.clear_wr ? {drrip_pkg::WAYS{drrip_pkg::RRPV_TOP}} : new_row;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (cmd.load) begin
         rd_row_ff <= mem[req_set_index];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_operation;
         set_ff       <= req_set_index;
         way_ff       <= req_way_index;
         hit_ff       <= req_was_hit;
         hash_zero_ff <= ~|(req_pc_value[drrip_pkg::HASH_LSB +: drrip_pkg::HASH_BITS] ^
                            req_phys_address[drrip_pkg::HASH_LSB +: drrip_pkg::HASH_BITS]);
      end
      victim_ff <= victim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= drrip_pkg::SEL_MID;
      end else begin
         sel_ff <= sel_in;
      end
   end

   assign rsp_victim_way     = victim_ff;
   assign rsp_selector_value = sel_ff;

endmodule

// ===== rtl/drrip_replacement_policy_top.sv =====
// The set row of a word is read from the single-port row memory in the
// accept cycle, then aged or updated and written back in the next, when
// the result is registered. A word is taken only after the last is written
// back and while no result waits unread. After reset a clearing pass sets
// all 2048 rows to the maximum, taking no word; the selector resets to 511.
// Top level; instantiates drrip_ctrl and drrip_dp, uses drrip_pkg.
module drrip_replacement_policy_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // set_index[10:0], way_index[14:11], was_hit[15], pc_value[79:16],
   // phys_address[143:80]
   input  logic [drrip_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // operation[0]
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // victim_way[3:0], selector_value[13:4], zero fill[15:14]
   output logic [drrip_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   drrip_pkg::cmd_type                  cmd;
   logic [drrip_pkg::WAY_BITS-1:0]      victim_way;
   logic [drrip_pkg::SEL_BITS-1:0]      selector_value;

   drrip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   drrip_dp u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .req_operation      (req_tuser),
      .req_set_index      (req_tdata[10:0]),
      .req_way_index      (req_tdata[14:11]),
      .req_was_hit        (req_tdata[15]),
      .req_pc_value       (req_tdata[79:16]),
      .req_phys_address   (req_tdata[143:80]),
      .rsp_victim_way     (victim_way),
      .rsp_selector_value (selector_value),
      .reset              (reset)
   );

   assign rsp_tdata = {2'b00, selector_value, victim_way};

endmodule

// ===== bench/drrip_replacement_policy_checker.sv =====
// Checker for the DRRIP replacement block: watches the request and response streams,
// keeps its own copy of the per-way re-reference values and the dueling selector,
// and compares every response word. Depends on drrip_pkg.
module drrip_replacement_policy_checker
   import drrip_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   // set_index[10:0], way_index[14:11], was_hit[15], pc_value[79:16],
   // phys_address[143:80]
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // operation[0]
   input  logic                     req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // victim_way[3:0], selector_value[13:4], zero fill[15:14]
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output int                       mismatch_count,
   output int                       words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIT_POS  = SET_BITS + WAY_BITS;
   localparam int PC_POS   = HIT_POS + 1;
   localparam int ADDR_POS = PC_POS + 64;

   typedef struct packed {
      logic [SEL_BITS-1:0] selector;
      logic [WAY_BITS-1:0] victim;
   } access_result_t;

   logic [AGE_BITS-1:0] rrpv [SETS][WAYS];
   logic [SEL_BITS-1:0] duel_sel;
   access_result_t      victim_selector_q [$];
   access_result_t      awaited;
   int                  words_seen;

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
      words_seen     = 0;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at response word %0d: %s got %0d want %0d",
               words_seen, what, got, want);
      mismatch_count++;
   endtask

   function automatic access_result_t apply_access(logic op, logic [SET_BITS-1:0] set_idx,
         logic [WAY_BITS-1:0] way, logic hit, logic [63:0] pc, logic [63:0] addr);
      access_result_t         res;
      logic [AGE_BITS-1:0]    oldest;
      logic [AGE_BITS-1:0]    fill;
      logic [SAMPLE_BITS-1:0] phase;
      logic [63:0]            mix;
      logic                   use_mru;
      logic                   found;
      int                     w;
      res.victim = '0;
      if (op == OP_FIND) begin
         oldest = '0;
         for (w = 0; w < WAYS; w++) begin
            if (rrpv[set_idx][w] > oldest) oldest = rrpv[set_idx][w];
         end
         if (oldest < RRPV_TOP) begin
            for (w = 0; w < WAYS; w++) begin
               rrpv[set_idx][w] = rrpv[set_idx][w] + (RRPV_TOP - oldest);
            end
         end
         found = 1'b0;
         for (w = 0; w < WAYS; w++) begin
            if (!found && rrpv[set_idx][w] == RRPV_TOP) begin
               res.victim = WAY_BITS'(w);
               found      = 1'b1;
            end
         end
      end else begin
         phase = set_idx[SAMPLE_BITS-1:0];
         if (hit) begin
            fill = '0;
            if (phase == PHASE_MRU) begin
               if (duel_sel < SEL_TOP) duel_sel = duel_sel + 1'b1;
            end else if (phase == PHASE_BIP) begin
               if (duel_sel > '0) duel_sel = duel_sel - 1'b1;
            end
         end else begin
            if (phase == PHASE_MRU) use_mru = 1'b1;
            else if (phase == PHASE_BIP) use_mru = 1'b0;
            else use_mru = (duel_sel >= SEL_MID);
            mix = pc ^ addr;
            if (use_mru || mix[HASH_LSB +: HASH_BITS] == '0) fill = '0;
            else fill = RRPV_TOP;
         end
         if (int'(way) < WAYS) rrpv[set_idx][way] = fill;
      end
      res.selector = duel_sel;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) rrpv[s][w] = RRPV_TOP;
         end
         duel_sel = SEL_MID;
         victim_selector_q.delete();
         words_pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (victim_selector_q.size() == 0) begin
               report_mismatch("response with no request outstanding", int'(rsp_tdata), -1);
            end else begin
               awaited = victim_selector_q.pop_front();
               if (rsp_tdata[WAY_BITS-1:0] !== awaited.victim)
                  report_mismatch("victim_way", int'(rsp_tdata[WAY_BITS-1:0]),
                                  int'(awaited.victim));
               if (rsp_tdata[WAY_BITS +: SEL_BITS] !== awaited.selector)
                  report_mismatch("selector_value", int'(rsp_tdata[WAY_BITS +: SEL_BITS]),
                                  int'(awaited.selector));
            end
         end
         if (req_tvalid && req_tready) begin
            victim_selector_q.push_back(apply_access(req_tuser,
               req_tdata[SET_BITS-1:0], req_tdata[SET_BITS +: WAY_BITS],
               req_tdata[HIT_POS], req_tdata[PC_POS +: 64], req_tdata[ADDR_POS +: 64]));
         end
         words_pending <= victim_selector_q.size();
      end
   end

endmodule

// ===== bench/drrip_replacement_policy_top_tb.sv =====
// Testbench top for the DRRIP replacement block: clock, reset, request and response
// stream drivers and the final verdict. Depends on drrip_pkg,
// drrip_replacement_policy_top and drrip_replacement_policy_checker.
module drrip_replacement_policy_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import drrip_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_WORDS    = 1720;
   localparam int UP_WORDS        = 540;
   localparam int DOWN_WORDS      = 1080;
   localparam int LEAN_PCT        = 98;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int UPPER_BITS      = SET_BITS - SAMPLE_BITS;
   localparam logic [63:0] HASH_FIELD = 64'((1 << HASH_BITS) - 1) << HASH_LSB;

   typedef enum {LEAN_NONE, LEAN_UP, LEAN_DOWN} lean_t;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   int                       mismatch_count;
   int                       words_pending;
   int                       send_idle_pct = 0;
   int                       stall_pct     = 0;
   int                       hold_off_tag  = 0;
   int                       words_sent    = 0;
   int                       cycle_count   = 0;

   drrip_replacement_policy_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   drrip_replacement_policy_checker access_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("drrip_replacement_policy_top_tb failed");
         $finish;
      end
   end

   initial begin
      int seen_tag;
      int hold_left;
      seen_tag   = 0;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_tag != seen_tag) begin
            seen_tag  = hold_off_tag;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_word(logic op, logic [SET_BITS-1:0] set_idx, logic [WAY_BITS-1:0] way,
         logic hit, logic [63:0] pc, logic [63:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {addr, pc, hit, way, set_idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
   endtask

   task automatic random_word(lean_t lean);
      logic                op;
      logic [SET_BITS-1:0] set_idx;
      logic [WAY_BITS-1:0] way;
      logic                hit;
      logic [63:0]         pc;
      logic [63:0]         addr;
      int                  start;
      pc   = {$urandom, $urandom};
      addr = {$urandom, $urandom};
      way  = WAY_BITS'($urandom);
      hit  = 1'($urandom);
      if (lean != LEAN_NONE && $urandom_range(99) < LEAN_PCT) begin
         set_idx = {UPPER_BITS'($urandom), (lean == LEAN_UP) ? PHASE_MRU : PHASE_BIP};
         send_word(OP_UPDATE, set_idx, way, 1'b1, pc, addr);
      end else if ($urandom_range(99) < 6) begin
         // Touch every way of one set so that the following victim search may have to age the row.
         set_idx = {UPPER_BITS'($urandom_range(3)), SAMPLE_BITS'($urandom_range(2, 5))};
         start   = $urandom_range(WAYS - 1);
         for (int k = 0; k < WAYS; k++) begin
            hit  = ($urandom_range(3) != 0);
            addr = $urandom_range(1) ? pc ^ ({$urandom, $urandom} & ~HASH_FIELD)
                                     : {$urandom, $urandom};
            send_word(OP_UPDATE, set_idx, WAY_BITS'(start + k), hit, pc, addr);
         end
         send_word(OP_FIND, set_idx, way, hit, pc, addr);
      end else begin
         op = ($urandom_range(99) < 45) ? OP_FIND : OP_UPDATE;
         case ($urandom_range(7))
            0: set_idx = {UPPER_BITS'($urandom), PHASE_MRU};
            1: set_idx = {UPPER_BITS'($urandom), PHASE_BIP};
            2, 3, 4: set_idx = {UPPER_BITS'($urandom_range(3)),
                                SAMPLE_BITS'($urandom_range(2, 5))};
            default: set_idx = SET_BITS'($urandom);
         endcase
         if ($urandom_range(3) == 0) addr = pc ^ ({$urandom, $urandom} & ~HASH_FIELD);
         send_word(op, set_idx, way, hit, pc, addr);
      end
   endtask

   initial begin
      int    random_base;
      int    offset;
      lean_t lean;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_FIND;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(OP_FIND,   11'd0,    4'd0,  1'b0, '0,       '0);
      send_word(OP_UPDATE, 11'd0,    4'd15, 1'b1, '1,       '1);
      send_word(OP_UPDATE, 11'd1,    4'd0,  1'b1, '0,       '0);
      send_word(OP_UPDATE, 11'd1,    4'd4,  1'b0, 64'h80,   '0);
      send_word(OP_UPDATE, 11'd1,    4'd5,  1'b0, 64'h100,  64'h7);
      send_word(OP_UPDATE, 11'd2047, 4'd0,  1'b0, '0,       64'h8);
      send_word(OP_FIND,   11'd2047, 4'd9,  1'b1, '1,       '0);
      send_word(OP_UPDATE, 11'd64,   4'd2,  1'b0, '1,       '0);
      send_word(OP_UPDATE, 11'd65,   4'd7,  1'b1, '0,       '1);
      send_word(OP_UPDATE, 11'd2046, 4'd3,  1'b0, 64'hF8,   64'hF8);
      for (int w = 0; w < WAYS; w++) begin
         send_word(OP_UPDATE, 11'd2, WAY_BITS'(w), 1'b1, 64'h5555_5555_5555_5555, '0);
      end
      send_word(OP_FIND, 11'd2, 4'd0, 1'b0, '0, '0);

      random_base = words_sent;
      for (int ph = 0; ph < 4; ph++) begin
         wait_all_results();
         send_idle_pct = (ph == 1) ? 51 : (ph == 3) ? 25 : 0;
         stall_pct     = (ph == 2) ? 51 : (ph == 3) ? 25 : 0;
         if (ph == 0) hold_off_tag++;
         while (words_sent < random_base + (ph + 1) * RANDOM_WORDS / 4) begin
            offset = words_sent - random_base;
            if (offset < UP_WORDS) lean = LEAN_UP;
            else if (offset < UP_WORDS + DOWN_WORDS) lean = LEAN_DOWN;
            else lean = LEAN_NONE;
            random_word(lean);
         end
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("drrip_replacement_policy_top_tb passed");
      end else begin
         $display("drrip_replacement_policy_top_tb failed");
      end
      $finish;
   end

endmodule
